FILE: rtl/kct_pkg.sv
package kct_pkg;

    localparam int unsigned TOTAL_W = 13;

    // Phase codes as shown on the result channel
    localparam logic [1:0] PHASE_ENTRY = 2'd0;
    localparam logic [1:0] PHASE_RUN   = 2'd1;
    localparam logic [1:0] PHASE_DONE  = 2'd2;

    // Key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_CANCEL    = 4'd10;
    localparam logic [3:0] KEY_ENTER     = 4'd11;

    localparam logic [2:0] MAX_DIGITS = 3'd4;

    localparam logic [TOTAL_W-1:0] SEC_PER_TEN_MIN = TOTAL_W'(600);
    localparam logic [TOTAL_W-1:0] SEC_PER_MIN     = TOTAL_W'(60);
    localparam logic [TOTAL_W-1:0] SEC_PER_TEN_SEC = TOTAL_W'(10);

    // Digit limits of the MM:SS display
    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [3:0] TENS_SEC_MAX = 4'd5;
    localparam logic [3:0] TENS_SEC_WRAP = 4'd6;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        digit_t mt;
        digit_t mu;
        digit_t st;
        digit_t su;
    } time_digits_t;

    typedef struct packed {
        logic       func;
        logic [3:0] key;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic [3:0]         minute_tens;
        logic [3:0]         minute_units;
        logic [3:0]         second_tens;
        logic [3:0]         second_units;
        logic [2:0]         digits_entered;
        logic [TOTAL_W-1:0] seconds_left;
        logic               beep;
    } out_item_t;

    // Commit results: total seconds and the same time in normalized digits
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               zero;
        time_digits_t       norm;
    } commit_t;

    // One countdown step
    typedef struct packed {
        logic [TOTAL_W-1:0] remaining;
        logic               finish;
        time_digits_t       digits;
    } tick_t;

endpackage

FILE: rtl/kct_commit.sv
module kct_commit
    import kct_pkg::*;
(
    input  time_digits_t entered,
    output commit_t      result
);

    logic         sec_carry;
    logic [3:0]   mu_sum;
    time_digits_t norm;

    // Fold seconds of 60 or more into the minutes, then carry the minutes
    always_comb
    begin
        sec_carry = (entered.st >= TENS_SEC_WRAP);
        norm.su   = entered.su;
        norm.st   = sec_carry ? (entered.st - TENS_SEC_WRAP) : entered.st;
        mu_sum    = entered.mu + {3'b000, sec_carry};
        if (mu_sum == DECIMAL_BASE)
        begin
            norm.mu = '0;
            norm.mt = entered.mt + 4'd1;
        end
        else
        begin
            norm.mu = mu_sum;
            norm.mt = entered.mt;
        end
    end

    assign result.total = TOTAL_W'(entered.mt) * SEC_PER_TEN_MIN
                        + TOTAL_W'(entered.mu) * SEC_PER_MIN
                        + TOTAL_W'(entered.st) * SEC_PER_TEN_SEC
                        + TOTAL_W'(entered.su);
    assign result.zero  = (entered == '0);
    assign result.norm  = norm;

endmodule

FILE: rtl/kct_countdown.sv
module kct_countdown
    import kct_pkg::*;
(
    input  logic [TOTAL_W-1:0] remaining,
    input  time_digits_t       digits,
    output tick_t              result
);

    logic borrow_su;
    logic borrow_st;
    logic borrow_mu;

    // Mixed-radix decrement of M:M:S:S; the result is used only when the value is at least two
    always_comb
    begin
        borrow_su = (digits.su == '0);
        borrow_st = borrow_su && (digits.st == '0);
        borrow_mu = borrow_st && (digits.mu == '0);

        result.digits.su = borrow_su ? DIGIT_MAX : (digits.su - 4'd1);
        result.digits.st = !borrow_su ? digits.st
                         : (borrow_st ? TENS_SEC_MAX : (digits.st - 4'd1));
        result.digits.mu = !borrow_st ? digits.mu
                         : (borrow_mu ? DIGIT_MAX : (digits.mu - 4'd1));
        result.digits.mt = borrow_mu ? (digits.mt - 4'd1) : digits.mt;

        result.remaining = remaining - TOTAL_W'(1);
        result.finish    = (remaining <= TOTAL_W'(1));
    end

endmodule

FILE: rtl/keypad_countdown_timer_top.sv
// Keypad countdown timer.
//
// Input channel (in_valid / in_ready / in_data): one item is either a key
// press (func = 0, key 0-9 digit, 10 cancel, 11 enter) or a one-second tick
// (func = 1). Output channel (out_valid / out_ready / out_data): exactly one
// result item per input item, showing phase, the four MM:SS digits, the
// count of keyed digits, the seconds left while running and a beep pulse.
//
// The state update and the result are computed in the cycle the item is
// accepted and the result is loaded into the output register. Throughput
// is one item per cycle while the receiver takes results; the single output
// register is refilled in the same cycle it is drained.
//
// The running count is kept twice: as a binary total and as normalized
// digits that step down with borrows, so no division is needed per tick.
//
// Reset clears phase to entry, the digits, the digit count and the total,
// and empties the output register. When the receiver stalls, the result
// holds in the output register and in_ready drops until it is taken.
module keypad_countdown_timer_top
    import kct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        ST_ENTRY = PHASE_ENTRY,
        ST_RUN   = PHASE_RUN,
        ST_DONE  = PHASE_DONE
    } state_t;

    state_t             state_reg, state_next;
    time_digits_t       shown_reg, shown_next;     // digits on display
    time_digits_t       count_reg, count_next;     // normalized running digits
    logic [2:0]         entry_reg, entry_next;
    logic [TOTAL_W-1:0] remain_reg, remain_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    logic               beep;
    logic               accept;

    commit_t commit;
    tick_t   tick;

    kct_commit u_commit
    (
        .entered (shown_reg),
        .result  (commit)
    );

    kct_countdown u_countdown
    (
        .remaining (remain_reg),
        .digits    (count_reg),
        .result    (tick)
    );

    // Take a new item whenever the output register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        shown_next  = shown_reg;
        count_next  = count_reg;
        entry_next  = entry_reg;
        remain_next = remain_reg;
        beep        = 1'b0;

        unique case (state_reg)
            ST_ENTRY:
            begin
                if (!in_data.func)
                begin
                    if (in_data.key == KEY_CANCEL)
                    begin
                        shown_next = '0;
                        entry_next = '0;
                        beep       = 1'b1;
                    end
                    else if (in_data.key == KEY_ENTER)
                    begin
                        // Enter with nothing keyed in is ignored
                        if (entry_reg != '0)
                        begin
                            beep = 1'b1;
                            if (commit.zero)
                            begin
                                state_next  = ST_DONE;
                                shown_next  = '0;
                                remain_next = '0;
                            end
                            else
                            begin
                                state_next  = ST_RUN;
                                remain_next = commit.total;
                                count_next  = commit.norm;
                            end
                        end
                    end
                    else if (in_data.key <= KEY_DIGIT_MAX)
                    begin
                        // Place the digit left to right; drop it once full
                        if (entry_reg < MAX_DIGITS)
                        begin
                            unique case (entry_reg[1:0])
                                2'd0:    shown_next.mt = in_data.key;
                                2'd1:    shown_next.mu = in_data.key;
                                2'd2:    shown_next.st = in_data.key;
                                default: shown_next.su = in_data.key;
                            endcase
                            entry_next = entry_reg + 3'd1;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (in_data.func)
                begin
                    if (tick.finish)
                    begin
                        state_next  = ST_DONE;
                        shown_next  = '0;
                        remain_next = '0;
                        beep        = 1'b1;
                    end
                    else
                    begin
                        remain_next = tick.remaining;
                        count_next  = tick.digits;
                        shown_next  = tick.digits;
                    end
                end
            end
            ST_DONE:
            begin
                // Hold: nothing changes once finished
            end
            default:
            begin
                state_next = ST_ENTRY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ENTRY;
            shown_reg     <= '0;
            count_reg     <= '0;
            entry_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg  <= state_next;
                shown_reg  <= shown_next;
                count_reg  <= count_next;
                entry_reg  <= entry_next;
                remain_reg <= remain_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register: payload only, loaded with the post-update view
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.phase          <= state_next;
            out_data_reg.minute_tens    <= shown_next.mt;
            out_data_reg.minute_units   <= shown_next.mu;
            out_data_reg.second_tens    <= shown_next.st;
            out_data_reg.second_units   <= shown_next.su;
            out_data_reg.digits_entered <= entry_next;
            out_data_reg.seconds_left   <= (state_next == ST_RUN) ? remain_next : '0;
            out_data_reg.beep           <= beep;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/kct_checker.sv
module kct_checker
    import kct_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Finished results show a blank display
    a_done_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.phase == PHASE_DONE) |->
            (out_data.minute_tens == '0) && (out_data.minute_units == '0) &&
            (out_data.second_tens == '0) && (out_data.second_units == '0) &&
            (out_data.seconds_left == '0))
        else $error("finished result not blank");

    // A running result always has time left
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.phase == PHASE_RUN) |-> (out_data.seconds_left != '0))
        else $error("running with zero seconds left");

    // A beep while still entering can only come from cancel
    a_cancel_beep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.beep && (out_data.phase == PHASE_ENTRY) |->
            (out_data.digits_entered == '0) && (out_data.seconds_left == '0))
        else $error("entry beep without cleared entry");

endmodule

bind keypad_countdown_timer_top kct_checker u_kct_checker (.*);
